### sv/tcw_pkg.sv
// shared constants for the text console writer
package tcw_pkg;

  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CURSOR_W = 11;
  localparam int Q_W      = 7;
  localparam int CCOL_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RST     = 8'd15;

endpackage

### sv/tcw_if.sv
// channel interfaces for requests, results and configuration
interface tcw_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::REQ_W-1:0]   req_type;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic                        use_cursor;
  logic [tcw_pkg::COL_W-1:0]   col;
  logic [tcw_pkg::ROW_W-1:0]   row;
  logic [tcw_pkg::ATTR_W-1:0]  attr;
  modport source (output valid, req_type, char_code, use_cursor, col, row, attr, input ready);
  modport sink (input valid, req_type, char_code, use_cursor, col, row, attr, output ready);
endinterface

interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CHAR_W-1:0]   cell_char;
  logic [tcw_pkg::ATTR_W-1:0]   cell_attr;
  logic [tcw_pkg::CURSOR_W-1:0] cursor_cell;
  logic                         scrolled;
  modport source (output valid, cell_char, cell_attr, cursor_cell, scrolled, input ready);
  modport sink (input valid, cell_char, cell_attr, cursor_cell, scrolled, output ready);
endinterface

interface tcw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::ATTR_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### sv/text_console_writer_top.sv
// text console writer top level: channels, attribute register, cell memory
// Usage:
//   in_ch carries put, read and clear items; out_ch returns one result item
//   per accepted item, in order; cfg_ch writes the default attribute and is
//   always ready. The default attribute resets to 15.
//   After reset an initial pass zeroes every cell, one cell a cycle, and the
//   block accepts no item until that pass is done.
//   One item is worked on at a time, through the single read-modify-write
//   path to the cell memory. A put first folds each whole row out of an
//   oversized column (col / COLS) into the row number, then writes the
//   cell unless it is a newline; a put that scrolls then moves every cell up
//   one row, one memory move per cycle. A clear is one pass over every cell.
//   Results sit in an output register; the next item is accepted while a
//   result waits, and a second result waits in the done step until the
//   receiver takes the first one.
module text_console_writer_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);

  import tcw_pkg::*;

  localparam int NCELLS = COLS * ROWS;
  localparam int ADDR_W = $clog2(NCELLS);

  logic [ATTR_W-1:0] default_attr_r;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [CELL_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [CELL_W-1:0] mem_wr_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= ATTR_RST;
    end else if (cfg_ch.valid) begin
      default_attr_r <= cfg_ch.data;
    end
  end

  tcw_ctrl #(
    .COLS   (COLS),
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .default_attr    (default_attr_r),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_req_type     (in_ch.req_type),
    .in_char_code    (in_ch.char_code),
    .in_use_cursor   (in_ch.use_cursor),
    .in_col          (in_ch.col),
    .in_row          (in_ch.row),
    .in_attr         (in_ch.attr),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_cell_char   (out_ch.cell_char),
    .out_cell_attr   (out_ch.cell_attr),
    .out_cursor_cell (out_ch.cursor_cell),
    .out_scrolled    (out_ch.scrolled),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data)
  );

  tcw_ram #(
    .DEPTH  (NCELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (CELL_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

### sv/tcw_ram.sv
// screen cell memory, one write and one registered read port
module tcw_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/tcw_ctrl.sv
// request sequencer: cursor, put, read, scroll and clear passes, result register
module tcw_ctrl #(
  parameter int COLS   = 80,
  parameter int ROWS   = 25,
  parameter int ADDR_W = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tcw_pkg::ATTR_W-1:0]    default_attr,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::REQ_W-1:0]     in_req_type,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic                          in_use_cursor,
  input  logic [tcw_pkg::COL_W-1:0]     in_col,
  input  logic [tcw_pkg::ROW_W-1:0]     in_row,
  input  logic [tcw_pkg::ATTR_W-1:0]    in_attr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::CHAR_W-1:0]    out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]    out_cell_attr,
  output logic [tcw_pkg::CURSOR_W-1:0]  out_cursor_cell,
  output logic                          out_scrolled,
  output logic                          mem_rd_en,
  output logic [ADDR_W-1:0]             mem_rd_addr,
  input  logic [tcw_pkg::CELL_W-1:0]    mem_rd_data,
  output logic                          mem_wr_en,
  output logic [ADDR_W-1:0]             mem_wr_addr,
  output logic [tcw_pkg::CELL_W-1:0]    mem_wr_data
);

  import tcw_pkg::*;

  localparam int NCELLS = COLS * ROWS;
  localparam int LIN_W  = $clog2(96 * COLS + 128);

  localparam logic [ADDR_W-1:0]   LAST_CELL  = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0]   SHIFT_END  = ADDR_W'(NCELLS - COLS);
  localparam logic [ADDR_W-1:0]   COLS_A     = ADDR_W'(COLS);
  localparam logic [LIN_W-1:0]    NCELLS_L   = LIN_W'(NCELLS);
  localparam logic [LIN_W-1:0]    COLS_L     = LIN_W'(COLS);
  localparam logic [CCOL_W:0]     COLS_C     = (CCOL_W + 1)'(COLS);
  localparam logic [Q_W-1:0]      LAST_ROW   = Q_W'(ROWS - 1);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_NORM   = 7'b0000100,
    S_PUT    = 7'b0001000,
    S_READ   = 7'b0010000,
    S_SCROLL = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    sc_r, sc_nxt;
  logic                 fill_r, fill_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic                 pend_zero_r, pend_zero_nxt;
  logic [ADDR_W-1:0]    pend_addr_r, pend_addr_nxt;
  logic [ADDR_W-1:0]    cur_lin_r, cur_lin_nxt;
  logic [Q_W-1:0]       cur_row_r, cur_row_nxt;
  logic [CCOL_W-1:0]    cur_col_r, cur_col_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [CHAR_W-1:0]    ch_r, ch_nxt;
  logic [ATTR_W-1:0]    at_r, at_nxt;
  logic [Q_W-1:0]       q_r, q_nxt;
  logic [CCOL_W-1:0]    rem_r, rem_nxt;
  logic [LIN_W-1:0]     lin_r, lin_nxt;
  logic                 rd_ok_r, rd_ok_nxt;
  logic [CHAR_W-1:0]    res_char_r, res_char_nxt;
  logic [ATTR_W-1:0]    res_attr_r, res_attr_nxt;
  logic                 res_scr_r, res_scr_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic [ATTR_W-1:0]    out_attr_r, out_attr_nxt;
  logic [CURSOR_W-1:0]  out_cursor_r, out_cursor_nxt;
  logic                 out_scr_r, out_scr_nxt;

  logic                 in_fire;
  logic [LIN_W-1:0]     in_cell;
  logic                 in_cell_ok;
  logic                 is_newline;
  logic [Q_W-1:0]       q_inc;
  logic [CCOL_W:0]      rem_inc;
  logic                 rem_wrap;
  logic [LIN_W-1:0]     put_lin;
  logic                 put_scroll;
  logic                 put_wr;
  logic                 out_free;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_cell    = LIN_W'(in_row) * COLS_L + LIN_W'(in_col);
  assign in_cell_ok = in_cell < NCELLS_L;
  assign is_newline = (ch_r == NEWLINE_CODE);
  assign q_inc      = q_r + Q_W'(1);
  assign rem_inc    = {1'b0, rem_r} + (CCOL_W + 1)'(1);
  assign rem_wrap   = (rem_inc == COLS_C);
  assign put_lin    = is_newline ? LIN_W'(q_inc) * COLS_L : lin_r + LIN_W'(1);
  assign put_scroll = put_lin >= NCELLS_L;
  assign put_wr     = !is_newline && (lin_r < NCELLS_L);
  assign out_free   = !out_valid_r || out_ready;

  // memory ports
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = sc_r + COLS_A;
    mem_wr_en   = 1'b0;
    mem_wr_addr = sc_r;
    mem_wr_data = '0;
    if (state_r == S_IDLE) begin
      mem_rd_en   = in_fire && (in_req_type == REQ_READ) && in_cell_ok;
      mem_rd_addr = in_cell[ADDR_W-1:0];
    end else if (state_r == S_SCROLL && !fill_r) begin
      mem_rd_en = (sc_r < SHIFT_END);
    end
    if (pend_v_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = pend_addr_r;
      mem_wr_data = pend_zero_r ? '0 : mem_rd_data;
    end else if (state_r == S_INIT) begin
      mem_wr_en = 1'b1;
    end else if (state_r == S_PUT) begin
      mem_wr_en   = put_wr;
      mem_wr_addr = lin_r[ADDR_W-1:0];
      mem_wr_data = {at_r, ch_r};
    end else if (state_r == S_SCROLL && fill_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_data = (sc_r < SHIFT_END) ? {default_attr, SPACE_CODE} : '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    sc_nxt         = sc_r;
    fill_nxt       = fill_r;
    pend_v_nxt     = 1'b0;
    pend_zero_nxt  = sc_r >= SHIFT_END;
    pend_addr_nxt  = sc_r;
    cur_lin_nxt    = cur_lin_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ch_nxt         = ch_r;
    at_nxt         = at_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    lin_nxt        = lin_r;
    rd_ok_nxt      = rd_ok_r;
    res_char_nxt   = res_char_r;
    res_attr_nxt   = res_attr_r;
    res_scr_nxt    = res_scr_r;
    out_char_nxt   = out_char_r;
    out_attr_nxt   = out_attr_r;
    out_cursor_nxt = out_cursor_r;
    out_scr_nxt    = out_scr_r;
    unique case (state_r)
      S_INIT: begin
        sc_nxt = sc_r + ADDR_W'(1);
        if (sc_r == LAST_CELL) begin
          sc_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          ch_nxt       = in_char_code;
          at_nxt       = (in_attr == '0) ? default_attr : in_attr;
          q_nxt        = in_use_cursor ? cur_row_r : Q_W'(in_row);
          rem_nxt      = in_use_cursor ? cur_col_r : CCOL_W'(in_col);
          lin_nxt      = in_use_cursor ? LIN_W'(cur_lin_r) : in_cell;
          rd_ok_nxt    = in_cell_ok;
          res_char_nxt = '0;
          res_attr_nxt = '0;
          res_scr_nxt  = 1'b0;
          sc_nxt       = '0;
          case (in_req_type)
            REQ_PUT:  state_nxt = S_NORM;
            REQ_READ: state_nxt = S_READ;
            REQ_CLEAR: begin
              fill_nxt    = 1'b1;
              res_scr_nxt = 1'b1;
              cur_lin_nxt = '0;
              cur_row_nxt = '0;
              cur_col_nxt = '0;
              state_nxt   = S_SCROLL;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_NORM: begin
        // fold columns past the row width into the row number
        if ({1'b0, rem_r} >= COLS_C) begin
          rem_nxt = CCOL_W'({1'b0, rem_r} - COLS_C);
          q_nxt   = q_inc;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        res_scr_nxt = put_scroll;
        if (put_scroll) begin
          cur_lin_nxt = SHIFT_END;
          cur_row_nxt = LAST_ROW;
          cur_col_nxt = '0;
          fill_nxt    = 1'b0;
          state_nxt   = S_SCROLL;
        end else begin
          cur_lin_nxt = put_lin[ADDR_W-1:0];
          cur_row_nxt = (is_newline || rem_wrap) ? q_inc : q_r;
          cur_col_nxt = (is_newline || rem_wrap) ? '0 : rem_inc[CCOL_W-1:0];
          state_nxt   = S_DONE;
        end
      end
      S_READ: begin
        res_char_nxt = rd_ok_r ? mem_rd_data[CHAR_W-1:0] : '0;
        res_attr_nxt = rd_ok_r ? mem_rd_data[CELL_W-1:CHAR_W] : '0;
        state_nxt    = S_DONE;
      end
      S_SCROLL: begin
        pend_v_nxt = !fill_r;
        sc_nxt     = sc_r + ADDR_W'(1);
        if (sc_r == LAST_CELL) begin
          sc_nxt    = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = res_char_r;
          out_attr_nxt   = res_attr_r;
          out_cursor_nxt = CURSOR_W'(cur_lin_r);
          out_scr_nxt    = res_scr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sc_r        <= '0;
      fill_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      cur_lin_r   <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      fill_r      <= fill_nxt;
      pend_v_r    <= pend_v_nxt;
      cur_lin_r   <= cur_lin_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_zero_r  <= pend_zero_nxt;
    pend_addr_r  <= pend_addr_nxt;
    ch_r         <= ch_nxt;
    at_r         <= at_nxt;
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    lin_r        <= lin_nxt;
    rd_ok_r      <= rd_ok_nxt;
    res_char_r   <= res_char_nxt;
    res_attr_r   <= res_attr_nxt;
    res_scr_r    <= res_scr_nxt;
    out_char_r   <= out_char_nxt;
    out_attr_r   <= out_attr_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_scr_r    <= out_scr_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_cell_char   = out_char_r;
  assign out_cell_attr   = out_attr_r;
  assign out_cursor_cell = out_cursor_r;
  assign out_scrolled    = out_scr_r;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    LIN_W'(cur_lin_r) < NCELLS_L)
    else $error("cursor outside the screen");

  a_cursor_coords: assert property (@(posedge clk) disable iff (!rst_n)
    LIN_W'(cur_row_r) * COLS_L + LIN_W'(cur_col_r) == LIN_W'(cur_lin_r))
    else $error("cursor row and column disagree with cell index");

  a_pend_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("shift write still pending at item boundary");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after done");

endmodule

### test/testbench.sv
// self-checking testbench for the text console writer with a mirrored screen store
module testbench;
  import tcw_pkg::*;

  localparam int COLS            = 80;
  localparam int ROWS            = 25;
  localparam int NCELLS          = COLS * ROWS;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PHASES          = 5;
  localparam int HOLD_CYCLES     = 5000;
  localparam int STALL_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 20;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic              use_cursor;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ATTR_W-1:0] attr;
  } console_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;
    logic [CURSOR_W-1:0] cursor_cell;
    logic                scrolled;
  } console_res_t;

  class screen_mirror;
    logic [CELL_W-1:0] cells [NCELLS];
    int unsigned       cursor;
    logic [ATTR_W-1:0] default_attr;
    console_res_t      pending_results [$];
    int                mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cursor       = 0;
      default_attr = ATTR_RST;
      mismatches   = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_default_attr(logic [ATTR_W-1:0] a);
      default_attr = a;
    endfunction

    function void scroll_up();
      for (int i = 0; i < NCELLS - COLS; i++) cells[i] = cells[i + COLS];
      for (int i = NCELLS - COLS; i < NCELLS; i++) cells[i] = '0;
    endfunction

    function void note_request(console_req_t rq);
      console_res_t      res;
      int unsigned       addr;
      int unsigned       pos;
      logic [ATTR_W-1:0] a;
      res  = '0;
      addr = int'(rq.row) * COLS + int'(rq.col);
      case (rq.req_type)
        REQ_PUT: begin
          pos = rq.use_cursor ? cursor : addr;
          a   = (rq.attr == '0) ? default_attr : rq.attr;
          if (rq.char_code == NEWLINE_CODE) begin
            pos = (pos / COLS + 1) * COLS;
          end else begin
            if (pos < NCELLS) cells[pos] = {a, rq.char_code};
            pos = pos + 1;
          end
          if (pos >= NCELLS) begin
            scroll_up();
            res.scrolled = 1'b1;
            pos = NCELLS - COLS;
          end
          cursor = pos;
        end
        REQ_READ: begin
          if (addr < NCELLS) {res.cell_attr, res.cell_char} = cells[addr];
        end
        REQ_CLEAR: begin
          foreach (cells[i]) cells[i] = {default_attr, SPACE_CODE};
          scroll_up();
          res.scrolled = 1'b1;
          cursor = 0;
        end
        default: begin
        end
      endcase
      res.cursor_cell = CURSOR_W'(cursor);
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(console_res_t got);
      console_res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual char %0d attr %0d cursor %0d scrolled %0d",
                 $time, got.cell_char, got.cell_attr, got.cursor_cell, got.scrolled);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("cell_char", want.cell_char, got.cell_char);
      compare_field("cell_attr", want.cell_attr, got.cell_attr);
      compare_field("cursor_cell", want.cursor_cell, got.cursor_cell);
      compare_field("scrolled", want.scrolled, got.scrolled);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();
  tcw_cfg_if cfg_ch ();

  text_console_writer_top #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #10 clk = ~clk;

  screen_mirror sb;
  bit           hold_off_req;
  bit           quiet_tail;
  int           idle_cycles = 0;
  console_req_t seen_req;
  console_res_t seen_res;

  // monitor: results are checked before the same edge's item is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen_res = '{cell_char: out_ch.cell_char, cell_attr: out_ch.cell_attr,
                     cursor_cell: out_ch.cursor_cell, scrolled: out_ch.scrolled};
        sb.check_result(seen_res);
      end
      if (cfg_ch.valid && cfg_ch.ready) sb.set_default_attr(cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        seen_req = '{req_type: in_ch.req_type, char_code: in_ch.char_code,
                     use_cursor: in_ch.use_cursor, col: in_ch.col, row: in_ch.row,
                     attr: in_ch.attr};
        sb.note_request(seen_req);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL text_console_writer_top");
      $finish;
    end
  end

  // receiver side
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic console_req_t make_req(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                            logic usec, logic [COL_W-1:0] c,
                                            logic [ROW_W-1:0] r, logic [ATTR_W-1:0] a);
    return '{req_type: kind, char_code: ch, use_cursor: usec, col: c, row: r, attr: a};
  endfunction

  // mostly on screen, sometimes past the last column or row
  function automatic logic [COL_W-1:0] rand_col();
    return ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(0, 127))
                                       : COL_W'($urandom_range(0, COLS - 1));
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(0, 31))
                                       : ROW_W'($urandom_range(0, ROWS - 1));
  endfunction

  function automatic console_req_t random_req();
    int unsigned       pick;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] a;
    pick = $urandom_range(0, 99);
    ch   = CHAR_W'($urandom_range(0, 255));
    a    = ($urandom_range(0, 3) == 0) ? '0 : ATTR_W'($urandom_range(0, 255));
    // runs of text at the cursor
    if (pick < 45) begin
      if ($urandom_range(0, 19) == 0) ch = NEWLINE_CODE;
      return make_req(REQ_PUT, ch, 1'b1, COL_W'($urandom_range(0, 127)),
                      ROW_W'($urandom_range(0, 31)), a);
    end
    if (pick < 70) return make_req(REQ_PUT, ch, 1'b0, rand_col(), rand_row(), a);
    if (pick < 93) return make_req(REQ_READ, ch, 1'($urandom_range(0, 1)), rand_col(),
                                   rand_row(), a);
    if (pick < 95) return make_req(REQ_UNUSED, ch, 1'($urandom_range(0, 1)),
                                   COL_W'($urandom_range(0, 127)),
                                   ROW_W'($urandom_range(0, 31)), a);
    if (pick < 96) return make_req(REQ_CLEAR, ch, 1'($urandom_range(0, 1)),
                                   COL_W'($urandom_range(0, 127)),
                                   ROW_W'($urandom_range(0, 31)), a);
    return make_req(REQ_PUT, NEWLINE_CODE, 1'b0, rand_col(), rand_row(), a);
  endfunction

  // offer one item, wait for the handshake, then maybe leave a gap
  task automatic push_item(console_req_t rq);
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= rq.req_type;
    in_ch.char_code  <= rq.char_code;
    in_ch.use_cursor <= rq.use_cursor;
    in_ch.col        <= rq.col;
    in_ch.row        <= rq.row;
    in_ch.attr       <= rq.attr;
    do @(posedge clk); while (!in_ch.ready);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_default_attr(logic [ATTR_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [ATTR_W-1:0] attr_setting;
    sb = new();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_PUT;
    in_ch.char_code  <= '0;
    in_ch.use_cursor <= 1'b0;
    in_ch.col        <= '0;
    in_ch.row        <= '0;
    in_ch.attr       <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corners, scroll paths, linear addressing, clear
    push_item(make_req(REQ_READ,   8'h00,        1'b0, 7'd0,   5'd0,  8'h00));
    push_item(make_req(REQ_PUT,    8'h41,        1'b0, 7'd0,   5'd0,  8'h00));
    push_item(make_req(REQ_PUT,    8'h00,        1'b1, 7'd127, 5'd31, 8'hff));
    push_item(make_req(REQ_PUT,    8'hff,        1'b1, 7'd0,   5'd0,  8'h80));
    push_item(make_req(REQ_PUT,    NEWLINE_CODE, 1'b1, 7'd0,   5'd0,  8'h55));
    push_item(make_req(REQ_PUT,    8'h5a,        1'b0, 7'd79,  5'd24, 8'h1e));
    push_item(make_req(REQ_READ,   8'h00,        1'b0, 7'd79,  5'd23, 8'h00));
    push_item(make_req(REQ_READ,   8'h00,        1'b0, 7'd0,   5'd0,  8'h00));
    push_item(make_req(REQ_PUT,    8'h7e,        1'b0, 7'd127, 5'd31, 8'h01));
    push_item(make_req(REQ_PUT,    8'h4c,        1'b0, 7'd100, 5'd0,  8'h7f));
    push_item(make_req(REQ_READ,   8'h00,        1'b0, 7'd20,  5'd1,  8'h00));
    push_item(make_req(REQ_READ,   8'hff,        1'b1, 7'd127, 5'd31, 8'hff));
    push_item(make_req(REQ_READ,   8'h00,        1'b0, 7'd80,  5'd24, 8'h00));
    push_item(make_req(REQ_PUT,    NEWLINE_CODE, 1'b0, 7'd5,   5'd30, 8'h00));
    push_item(make_req(REQ_PUT,    NEWLINE_CODE, 1'b0, 7'd5,   5'd3,  8'h00));
    push_item(make_req(REQ_UNUSED, 8'haa,        1'b1, 7'h55,  5'h15, 8'haa));
    push_item(make_req(REQ_PUT,    8'h2a,        1'b1, 7'd0,   5'd0,  8'h00));
    push_item(make_req(REQ_CLEAR,  8'h00,        1'b0, 7'd0,   5'd0,  8'h00));
    push_item(make_req(REQ_READ,   8'h00,        1'b0, 7'd0,   5'd0,  8'h00));
    push_item(make_req(REQ_READ,   8'h00,        1'b0, 7'd79,  5'd24, 8'h00));
    push_item(make_req(REQ_PUT,    8'h31,        1'b0, 7'd78,  5'd24, 8'hc3));
    push_item(make_req(REQ_PUT,    8'h32,        1'b1, 7'd0,   5'd0,  8'h00));
    push_item(make_req(REQ_READ,   8'h00,        1'b0, 7'd78,  5'd23, 8'h00));

    for (int phase = 0; phase < PHASES; phase++) begin
      // sender pauses until every result is back, then reconfigures
      drain();
      case (phase)
        0:       attr_setting = 8'h00;
        1:       attr_setting = 8'hff;
        default: attr_setting = ATTR_W'($urandom_range(1, 254));
      endcase
      write_default_attr(attr_setting);
      if (phase == 1) hold_off_req = 1'b1;
      if (phase == PHASES - 1) quiet_tail = 1'b1;
      repeat (ITEMS_PER_PHASE) push_item(random_req());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS text_console_writer_top");
    end else begin
      $display("FAIL text_console_writer_top");
    end
    $finish;
  end
endmodule
